// ----- hw/rtl/bpc_pkg.sv -----
// shared types and constants for the barometric pressure compensation block
package bpc_pkg;

   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int DT_W    = 26;
   localparam int TEMP_W  = 15;
   localparam int PRESS_W = 17;
   localparam int CSR_W   = 3;

   typedef enum logic [CSR_W-1:0] {
      CSR_PRESSURE_SENSITIVITY   = 3'd0,
      CSR_PRESSURE_OFFSET        = 3'd1,
      CSR_SENSITIVITY_TEMP_COEFF = 3'd2,
      CSR_OFFSET_TEMP_COEFF      = 3'd3,
      CSR_REFERENCE_TEMPERATURE  = 3'd4,
      CSR_TEMPERATURE_COEFF      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CAL_W-1:0] pressure_sensitivity;
      logic [CAL_W-1:0] pressure_offset;
      logic [CAL_W-1:0] sensitivity_temp_coeff;
      logic [CAL_W-1:0] offset_temp_coeff;
      logic [CAL_W-1:0] reference_temperature;
      logic [CAL_W-1:0] temperature_coeff;
   } calib_type;

   typedef struct packed {
      logic [RAW_W-1:0]       raw_pressure;
      logic signed [DT_W-1:0] dt;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_push_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

endpackage

// ----- hw/rtl/bpc_req_if.sv -----
// input channel carrying one raw pressure and temperature pair
interface bpc_req_if;
   logic                     valid;
   logic                     ready;
   logic [bpc_pkg::RAW_W-1:0] raw_pressure;
   logic [bpc_pkg::RAW_W-1:0] raw_temperature;

   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ----- hw/rtl/bpc_rsp_if.sv -----
// result channel carrying compensated temperature and pressure
interface bpc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi;
   logic [bpc_pkg::PRESS_W-1:0]       pressure_centi;

   modport source (output valid, output temperature_centi, output pressure_centi, input ready);
   modport sink (input valid, input temperature_centi, input pressure_centi, output ready);
endinterface

// ----- hw/rtl/bpc_csr_if.sv -----
// calibration register write channel
interface bpc_csr_if;
   logic                      valid;
   logic                      ready;
   logic [bpc_pkg::CSR_W-1:0] index;
   logic [bpc_pkg::CAL_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/bpc_front.sv -----
// front end: calibration registers, input accept and temperature delta
module bpc_front (
   input  logic                    clock,
   input  logic                    reset,
   bpc_req_if.sink                 req,
   bpc_csr_if.sink                 csr,
   input  logic                    queue_full,
   output bpc_pkg::queue_push_type push,
   output bpc_pkg::calib_type      calib
);

   bpc_pkg::calib_type calib_ff;
   bpc_pkg::calib_type calib_in;

   always_comb begin
      calib_in = calib_ff;
      if (csr.valid) begin
         unique case (csr.index)
            bpc_pkg::CSR_PRESSURE_SENSITIVITY:   calib_in.pressure_sensitivity   = csr.data;
            bpc_pkg::CSR_PRESSURE_OFFSET:        calib_in.pressure_offset        = csr.data;
            bpc_pkg::CSR_SENSITIVITY_TEMP_COEFF: calib_in.sensitivity_temp_coeff = csr.data;
            bpc_pkg::CSR_OFFSET_TEMP_COEFF:      calib_in.offset_temp_coeff      = csr.data;
            bpc_pkg::CSR_REFERENCE_TEMPERATURE:  calib_in.reference_temperature  = csr.data;
            bpc_pkg::CSR_TEMPERATURE_COEFF:      calib_in.temperature_coeff      = csr.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff <= '0;
      end else begin
         calib_ff <= calib_in;
      end
   end

   assign calib     = calib_ff;
   assign csr.ready = 1'b1;
   assign req.ready = !queue_full;

   // dt = raw temperature minus reference scaled by 256
   assign push.valid              = req.valid && !queue_full;
   assign push.entry.raw_pressure = req.raw_pressure;
   assign push.entry.dt           = $signed({2'd0, req.raw_temperature})
                                  - $signed({2'd0, calib_ff.reference_temperature, 8'd0});

endmodule

// ----- hw/rtl/bpc_queue.sv -----
// short queue between front end and compensation pipeline
module bpc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bpc_pkg::queue_push_type push,
   input  logic                    pop,
   output bpc_pkg::queue_head_type head,
   output logic                    full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bpc_pkg::queue_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign head.valid = (count_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

// ----- hw/rtl/bpc_back.sv -----
// compensation pipeline: temperature, offset, sensitivity, second order and pressure
module bpc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bpc_pkg::calib_type      calib,
   input  bpc_pkg::queue_head_type head,
   output logic                    pop,
   bpc_rsp_if.source               rsp
);

   localparam int NST = 12;

   logic           en;
   logic [NST-1:0] vld_ff, vld_in;

   // stage 1: products with dt
   logic signed [25:0] dt;
   logic signed [42:0] s1_tprod_ff, s1_tprod_in;
   logic signed [42:0] s1_oprod_ff, s1_oprod_in;
   logic signed [42:0] s1_sprod_ff, s1_sprod_in;
   logic signed [51:0] s1_dsq_ff, s1_dsq_in;
   logic [7:1][23:0]   d1_ff, d1_in;

   // stage 2: first order terms
   logic signed [42:0] s2_tsh, s2_osh, s2_ssh;
   logic               s2_ocin, s2_scin;
   logic signed [20:0] s2_temp_ff, s2_temp_in;
   logic signed [41:0] s2_off_in, s2_sens_in;
   logic [19:0]        s2_t2_ff, s2_t2_in;
   logic [6:2][41:0]   off1_ff, off1_in;
   logic [6:2][41:0]   sens1_ff, sens1_in;

   // stage 3: low temperature classification
   logic               s3_lowt_in, s3_vlow_in;
   logic signed [20:0] s3_dlow_ff, s3_dlow_in;
   logic signed [20:0] s3_dvl_ff, s3_dvl_in;
   logic signed [20:0] s3_temp_in;
   logic [5:3]         lowt_ff, lowt_in;
   logic [4:3]         vlow_ff, vlow_in;
   logic [4:3][20:0]   temp_ff, temp_in;

   // stage 4: squares
   logic signed [41:0] s4_dlsq, s4_dvsq;
   logic [35:0]        s4_dlow2_ff, s4_dlow2_in;
   logic [35:0]        s4_dvl2_ff, s4_dvl2_in;

   // stage 5: scaled squares and temperature clamp
   logic [41:0]        s5_m61_ff, s5_m61_in;
   logic [39:0]        s5_m15_ff, s5_m15_in;
   logic [36:0]        s5_s2a_ff, s5_s2a_in;
   logic [38:0]        s5_m8_ff, s5_m8_in;
   logic signed [20:0] s5_temp;
   logic [14:0]        s5_tc_in;
   logic [11:5][14:0]  tc_ff, tc_in;

   // stage 6 and 7: second order offset and sensitivity
   logic [41:0]        s6_off2_ff, s6_off2_in;
   logic [41:0]        s6_sens2_ff, s6_sens2_in;
   logic signed [41:0] s7_off_in;
   logic signed [41:0] s7_sens_ff, s7_sens_in;
   logic [9:7][41:0]   off_ff, off_in;

   // stage 8 to 12: pressure
   logic [44:0]        s8_plo_ff, s8_plo_in;
   logic signed [45:0] s8_phi_ff, s8_phi_in;
   logic signed [66:0] s9_prod_ff, s9_prod_in;
   logic               s10_pcin;
   logic signed [47:0] s10_diff_ff, s10_diff_in;
   logic               s11_qcin;
   logic signed [32:0] s11_press_ff, s11_press_in;
   logic [16:0]        rsp_press_ff, rsp_press_in;
   logic [14:0]        rsp_temp_ff;

   assign en        = !vld_ff[NST-1] || rsp.ready;
   assign pop       = en;
   assign vld_in    = {vld_ff[NST-2:0], head.valid};
   assign rsp.valid = vld_ff[NST-1];
   assign rsp.temperature_centi = $signed(rsp_temp_ff);
   assign rsp.pressure_centi    = rsp_press_ff;

   // stage 1
   assign dt          = head.entry.dt;
   assign s1_tprod_in = dt * $signed({1'b0, calib.temperature_coeff});
   assign s1_oprod_in = dt * $signed({1'b0, calib.offset_temp_coeff});
   assign s1_sprod_in = dt * $signed({1'b0, calib.sensitivity_temp_coeff});
   assign s1_dsq_in   = dt * dt;
   assign d1_in       = {d1_ff[6:1], head.entry.raw_pressure};

   // stage 2: offset and sensitivity divisions truncate toward zero via carry in
   assign s2_tsh     = s1_tprod_ff >>> 23;
   assign s2_temp_in = $signed(s2_tsh[20:0]) + 21'sd2000;
   assign s2_osh     = s1_oprod_ff >>> 6;
   assign s2_ocin    = s1_oprod_ff[42] && (s1_oprod_ff[5:0] != 6'd0);
   assign s2_off_in  = $signed({9'd0, calib.pressure_offset, 17'd0})
                     + $signed(s2_osh[41:0]) + $signed({41'd0, s2_ocin});
   assign s2_ssh     = s1_sprod_ff >>> 7;
   assign s2_scin    = s1_sprod_ff[42] && (s1_sprod_ff[6:0] != 7'd0);
   assign s2_sens_in = $signed({10'd0, calib.pressure_sensitivity, 16'd0})
                     + $signed(s2_ssh[41:0]) + $signed({41'd0, s2_scin});
   assign s2_t2_in   = s1_dsq_ff[50:31];
   assign off1_in    = {off1_ff[5:2], s2_off_in};
   assign sens1_in   = {sens1_ff[5:2], s2_sens_in};

   // stage 3
   assign s3_lowt_in = s2_temp_ff < 21'sd2000;
   assign s3_vlow_in = s2_temp_ff < -21'sd1500;
   assign s3_dlow_in = s2_temp_ff - 21'sd2000;
   assign s3_dvl_in  = s2_temp_ff + 21'sd1500;
   assign s3_temp_in = s3_lowt_in ? (s2_temp_ff - $signed({1'b0, s2_t2_ff})) : s2_temp_ff;
   assign lowt_in    = {lowt_ff[4:3], s3_lowt_in};
   assign vlow_in    = {vlow_ff[3], s3_vlow_in};
   assign temp_in    = {temp_ff[3], s3_temp_in};

   // stage 4
   assign s4_dlsq     = s3_dlow_ff * s3_dlow_ff;
   assign s4_dvsq     = s3_dvl_ff * s3_dvl_ff;
   assign s4_dlow2_in = s4_dlsq[35:0];
   assign s4_dvl2_in  = s4_dvsq[35:0];

   // stage 5
   assign s5_m61_in = {s4_dlow2_ff, 6'd0} - {4'd0, s4_dlow2_ff, 2'd0} + {6'd0, s4_dlow2_ff};
   assign s5_m15_in = vlow_ff[4] ? ({s4_dvl2_ff, 4'd0} - {4'd0, s4_dvl2_ff}) : '0;
   assign s5_s2a_in = {s4_dlow2_ff, 1'b0};
   assign s5_m8_in  = vlow_ff[4] ? {s4_dvl2_ff, 3'd0} : '0;
   assign s5_temp   = $signed(temp_ff[4]);

   always_comb begin
      if (s5_temp < -21'sd4000) begin
         s5_tc_in = 15'h7fff & 15'(-16'sd4000);
      end else if (s5_temp > 21'sd8500) begin
         s5_tc_in = 15'd8500;
      end else begin
         s5_tc_in = s5_temp[14:0];
      end
   end

   assign tc_in = {tc_ff[10:5], s5_tc_in};

   // stage 6
   assign s6_off2_in  = lowt_ff[5] ? ({4'd0, s5_m61_ff[41:4]} + {2'd0, s5_m15_ff}) : '0;
   assign s6_sens2_in = lowt_ff[5] ? ({5'd0, s5_s2a_ff} + {3'd0, s5_m8_ff}) : '0;

   // stage 7
   assign s7_off_in  = $signed(off1_ff[6]) - $signed(s6_off2_ff);
   assign s7_sens_in = $signed(sens1_ff[6]) - $signed(s6_sens2_ff);
   assign off_in     = {off_ff[8:7], s7_off_in};

   // stage 8: raw pressure times sensitivity in two partial products
   assign s8_plo_in = d1_ff[7] * s7_sens_ff[20:0];
   assign s8_phi_in = $signed({1'b0, d1_ff[7]}) * $signed(s7_sens_ff[41:21]);

   // stage 9
   assign s9_prod_in = $signed({s8_phi_ff, 21'd0}) + $signed({22'd0, s8_plo_ff});

   // stage 10
   assign s10_pcin    = s9_prod_ff[66] && (s9_prod_ff[20:0] != 21'd0);
   assign s10_diff_in = $signed({{2{s9_prod_ff[66]}}, s9_prod_ff[66:21]})
                      + $signed({47'd0, s10_pcin})
                      - $signed({{6{off_ff[9][41]}}, off_ff[9]});

   // stage 11
   assign s11_qcin     = s10_diff_ff[47] && (s10_diff_ff[14:0] != 15'd0);
   assign s11_press_in = $signed(s10_diff_ff[47:15]) + $signed({32'd0, s11_qcin});

   // stage 12: pressure clamp
   always_comb begin
      if (s11_press_ff < 33'sd1000) begin
         rsp_press_in = 17'd1000;
      end else if (s11_press_ff > 33'sd120000) begin
         rsp_press_in = 17'd120000;
      end else begin
         rsp_press_in = s11_press_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tprod_ff  <= s1_tprod_in;
         s1_oprod_ff  <= s1_oprod_in;
         s1_sprod_ff  <= s1_sprod_in;
         s1_dsq_ff    <= s1_dsq_in;
         d1_ff        <= d1_in;
         s2_temp_ff   <= s2_temp_in;
         s2_t2_ff     <= s2_t2_in;
         off1_ff      <= off1_in;
         sens1_ff     <= sens1_in;
         s3_dlow_ff   <= s3_dlow_in;
         s3_dvl_ff    <= s3_dvl_in;
         lowt_ff      <= lowt_in;
         vlow_ff      <= vlow_in;
         temp_ff      <= temp_in;
         s4_dlow2_ff  <= s4_dlow2_in;
         s4_dvl2_ff   <= s4_dvl2_in;
         s5_m61_ff    <= s5_m61_in;
         s5_m15_ff    <= s5_m15_in;
         s5_s2a_ff    <= s5_s2a_in;
         s5_m8_ff     <= s5_m8_in;
         tc_ff        <= tc_in;
         s6_off2_ff   <= s6_off2_in;
         s6_sens2_ff  <= s6_sens2_in;
         s7_sens_ff   <= s7_sens_in;
         off_ff       <= off_in;
         s8_plo_ff    <= s8_plo_in;
         s8_phi_ff    <= s8_phi_in;
         s9_prod_ff   <= s9_prod_in;
         s10_diff_ff  <= s10_diff_in;
         s11_press_ff <= s11_press_in;
         rsp_press_ff <= rsp_press_in;
         rsp_temp_ff  <= tc_ff[11];
      end
   end

endmodule

// ----- hw/rtl/barometric_pressure_compensation.sv -----
// a sample pair is written to the input queue, then registered through each pipeline stage
// throughput: one sample pair per cycle in the 12 stage pipeline unless the result stalls
// the input queue of QUEUE_DEPTH entries takes input while a result stalls, until it is full
// reset is synchronous: clears the queue, pipeline valid bits and calibration words to zero
// top level of the barometric pressure compensation block
module barometric_pressure_compensation #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   bpc_req_if.sink   req_chan,
   bpc_rsp_if.source rsp_chan,
   bpc_csr_if.sink   csr_chan
);

   bpc_pkg::queue_push_type push;
   bpc_pkg::queue_head_type head;
   bpc_pkg::calib_type      calib;
   logic                    queue_full;
   logic                    pop;

   bpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .queue_full (queue_full),
      .push       (push),
      .calib      (calib)
   );

   bpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   bpc_back u_back (
      .clock (clock),
      .reset (reset),
      .calib (calib),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

`ifndef SYNTH
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.temperature_centi >= -15'sd4000 &&
                          rsp_chan.temperature_centi <= 15'sd8500))
      else $error("temperature out of range");

   a_press_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.pressure_centi >= 17'd1000 &&
                          rsp_chan.pressure_centi <= 17'd120000))
      else $error("pressure out of range");

   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      (push.valid && !queue_full) |=> head.valid)
      else $error("queue empty after transfer in");
`endif

endmodule
